>>> hw/rtl/cgi_pkg.sv
// cgi_pkg: shared widths, breakpoint tables and controller interface types
// for the curve gain interpolator. No dependencies; used by every rtl file.
package cgi_pkg;

  // fixed-point formats
  localparam int FREQ_FRAC_BITS = 4;
  localparam int GAIN_FRAC_BITS = 8;

  // field widths
  localparam int FREQ_W  = 20;
  localparam int GAIN_W  = 13;
  localparam int SEL_W   = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // table geometry
  localparam int NUM_CURVES = 6;
  localparam int MAX_POINTS = 9;
  localparam int IDX_W      = 4;
  localparam int HZ_W       = 15;
  localparam int DB_W       = 5;

  // datapath widths
  localparam int GS_W  = 16;                 // scaled gain, signed
  localparam int DEN_W = FREQ_W;             // interval width and offset
  localparam int MAG_W = 13;                 // magnitude of gain step
  localparam int Q_W   = MAG_W;              // quotient never exceeds the step
  localparam int PROD_W = MAG_W + DEN_W;     // step times offset
  localparam int N_W   = PROD_W + 2;         // numerator magnitude
  localparam int D2_W  = DEN_W + 1;          // doubled interval width
  localparam int REM_W = D2_W;
  localparam int CNT_W = $clog2(Q_W);

  localparam int OUT_MIN = -4096;
  localparam int OUT_MAX = 4095;

  typedef logic [HZ_W-1:0]        hz_t;
  typedef logic signed [DB_W-1:0] db_t;

  localparam hz_t HZ_ROM [NUM_CURVES][MAX_POINTS] = '{
    '{15'd20, 15'd20000, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0},
    '{15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0},
    '{15'd20, 15'd60, 15'd150, 15'd400, 15'd1000, 15'd3000, 15'd6000,
      15'd10000, 15'd20000},
    '{15'd20, 15'd200, 15'd1000, 15'd4000, 15'd10000, 15'd20000, 15'd0,
      15'd0, 15'd0},
    '{15'd20, 15'd200, 15'd1000, 15'd4000, 15'd10000, 15'd20000, 15'd0,
      15'd0, 15'd0},
    '{15'd20, 15'd100, 15'd500, 15'd2000, 15'd6000, 15'd20000, 15'd0,
      15'd0, 15'd0}
  };

  localparam db_t DB_ROM [NUM_CURVES][MAX_POINTS] = '{
    '{5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0},
    '{5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0},
    '{5'sd6, 5'sd4, 5'sd1, -5'sd1, 5'sd0, 5'sd2, 5'sd1, -5'sd1, -5'sd3},
    '{5'sd4, 5'sd2, 5'sd0, -5'sd2, -5'sd4, -5'sd6, 5'sd0, 5'sd0, 5'sd0},
    '{-5'sd2, 5'sd0, 5'sd0, 5'sd1, 5'sd0, -5'sd2, 5'sd0, 5'sd0, 5'sd0},
    '{5'sd8, 5'sd4, 5'sd0, 5'sd0, 5'sd3, 5'sd5, 5'sd0, 5'sd0, 5'sd0}
  };

  localparam logic [IDX_W-1:0] COUNT_ROM [NUM_CURVES] = '{
    4'd2, 4'd0, 4'd9, 4'd6, 4'd6, 4'd6
  };

  // breakpoint frequency scaled to the query format
  function automatic logic [FREQ_W-1:0] bp_freq(input logic [SEL_W-1:0] sel,
                                                input logic [IDX_W-1:0] idx);
    logic [FREQ_W-1:0] f;
    f = FREQ_W'(HZ_ROM[sel][idx]) << FREQ_FRAC_BITS;
    return f;
  endfunction

  // breakpoint gain scaled to the result format
  function automatic logic signed [GS_W-1:0] bp_gain(input logic [SEL_W-1:0] sel,
                                                     input logic [IDX_W-1:0] idx);
    logic signed [GS_W-1:0] g;
    g = GS_W'(DB_ROM[sel][idx]) <<< GAIN_FRAC_BITS;
    return g;
  endfunction

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic step;
    logic mult;
    logic numer;
    logic div;
    logic fin;
  } cgi_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic early;
    logic search_done;
    logic out_free;
  } cgi_status_t;

endpackage

>>> hw/rtl/cgi_ctrl.sv
// cgi_ctrl: sequencer for one query: endpoint check, binary search,
// multiply, numerator setup, serial division, result hand-off. Uses cgi_pkg.
module cgi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cgi_pkg::cgi_status_t status,
  output cgi_pkg::cgi_cmd_t    cmd
);
  import cgi_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHECK  = 7'b0000010,
    ST_SEARCH = 7'b0000100,
    ST_MULT   = 7'b0001000,
    ST_NUMER  = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;

  assign in_ready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.early ? ST_FIN : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (status.search_done) begin
          state_next = ST_MULT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_NUMER;
      end
      ST_NUMER: begin
        cmd.numer  = 1'b1;
        cnt_next   = CNT_W'(Q_W - 1);
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (cnt == '0) begin
          state_next = ST_FIN;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

>>> hw/rtl/cgi_dp.sv
// cgi_dp: curve select register, breakpoint search, multiplier, restoring
// divider and output register. Uses cgi_pkg tables; driven by cgi_ctrl.
module cgi_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cgi_pkg::SEL_W-1:0]    cfg_sel,
  input  logic [cgi_pkg::FREQ_W-1:0]   in_freq,
  input  cgi_pkg::cgi_cmd_t            cmd,
  output cgi_pkg::cgi_status_t         status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cgi_pkg::GAIN_W-1:0]   out_gain
);
  import cgi_pkg::*;

  logic [SEL_W-1:0]       curve_select;
  logic [SEL_W-1:0]       sel;
  logic [FREQ_W-1:0]      freq;
  logic [IDX_W-1:0]       lo, hi;
  logic                   early;
  logic signed [GS_W-1:0] early_gain;
  logic signed [GS_W-1:0] g0;
  logic [PROD_W-1:0]      prod;
  logic [DEN_W-1:0]       den;
  logic                   dg_neg;
  logic                   neg;
  logic [REM_W-1:0]       rem;
  logic [Q_W-1:0]         quo;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_select <= '0;
    end else if (cfg_we) begin
      curve_select <= cfg_sel;
    end
  end

  // endpoint checks on the captured query
  logic [IDX_W-1:0]       count, last;
  logic                   chk_early;
  logic signed [GS_W-1:0] chk_gain;

  always_comb begin
    count     = COUNT_ROM[sel];
    last      = count - 1'b1;
    chk_early = 1'b1;
    chk_gain  = '0;
    priority if (count == '0) begin
      chk_gain = '0;
    end else if (freq <= bp_freq(sel, '0)) begin
      chk_gain = bp_gain(sel, '0);
    end else if (freq >= bp_freq(sel, last)) begin
      chk_gain = bp_gain(sel, last);
    end else begin
      chk_early = 1'b0;
    end
  end

  // search step
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] mid;
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IDX_W:1];

  // interval terms
  logic [FREQ_W-1:0]      f0, f1;
  logic signed [GS_W-1:0] gl, gh, dg;
  logic [MAG_W-1:0]       mag;
  logic [DEN_W-1:0]       den_w, off_w;
  assign f0    = bp_freq(sel, lo);
  assign f1    = bp_freq(sel, hi);
  assign gl    = bp_gain(sel, lo);
  assign gh    = bp_gain(sel, hi);
  assign dg    = gh - gl;
  assign mag   = dg[GS_W-1] ? MAG_W'(-dg) : MAG_W'(dg);
  assign den_w = f1 - f0;
  assign off_w = freq - f0;

  // signed numerator 2*dg*d + den as magnitude and sign
  logic [N_W-1:0] pterm, dterm, nmag;
  logic           nneg;
  always_comb begin
    pterm = {1'b0, prod, 1'b0};
    dterm = N_W'(den);
    nneg  = 1'b0;
    priority if (!dg_neg) begin
      nmag = pterm + dterm;
    end else if (pterm <= dterm) begin
      nmag = dterm - pterm;
    end else begin
      nmag = pterm - dterm;
      nneg = 1'b1;
    end
  end

  // one restoring division step
  logic [D2_W-1:0]  d2;
  logic [REM_W:0]   trial;
  logic             qbit;
  logic [REM_W-1:0] rem_step;
  assign d2    = {den, 1'b0};
  assign trial = {rem, quo[Q_W-1]};
  assign qbit  = (trial >= {1'b0, d2});
  assign rem_step = qbit ? REM_W'(trial - {1'b0, d2}) : trial[REM_W-1:0];

  // final rounding fix-up and saturation
  logic [Q_W:0]           qmag;
  logic signed [GS_W:0]   sum;
  logic signed [GS_W:0]   res_wide;
  logic [GAIN_W-1:0]      res;
  always_comb begin
    qmag = {1'b0, quo} + {{Q_W{1'b0}}, (neg && rem != '0)};
    if (neg) begin
      sum = {g0[GS_W-1], g0} - (GS_W+1)'(qmag);
    end else begin
      sum = {g0[GS_W-1], g0} + (GS_W+1)'(qmag);
    end
    res_wide = early ? {early_gain[GS_W-1], early_gain} : sum;
    priority if (res_wide < (GS_W+1)'(OUT_MIN)) begin
      res = GAIN_W'(OUT_MIN);
    end else if (res_wide > (GS_W+1)'(OUT_MAX)) begin
      res = GAIN_W'(OUT_MAX);
    end else begin
      res = res_wide[GAIN_W-1:0];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      freq  <= in_freq;
      sel   <= (curve_select >= SEL_W'(NUM_CURVES)) ? '0 : curve_select;
      early <= 1'b0;
    end
    if (cmd.check) begin
      early      <= chk_early;
      early_gain <= chk_gain;
      lo         <= '0;
      hi         <= last;
    end
    if (cmd.step) begin
      if (bp_freq(sel, mid) <= freq) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.mult) begin
      prod   <= PROD_W'(mag) * PROD_W'(off_w);
      den    <= den_w;
      dg_neg <= dg[GS_W-1];
      g0     <= gl;
      // zero-width interval keeps the lower gain
      if (den_w == '0) begin
        early      <= 1'b1;
        early_gain <= gl;
      end
    end
    if (cmd.numer) begin
      neg <= nneg;
      rem <= REM_W'(nmag >> Q_W);
      quo <= nmag[Q_W-1:0];
    end
    if (cmd.div) begin
      rem <= rem_step;
      quo <= {quo[Q_W-2:0], qbit};
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_gain <= res;
    end
  end

  assign status.early       = chk_early;
  assign status.search_done = ({1'b0, lo} + 1'b1) >= {1'b0, hi};
  assign status.out_free    = !out_valid || out_ready;

endmodule

>>> hw/rtl/curve_gain_interpolator_top.sv
// curve_gain_interpolator_top: stream wrapper joining cgi_ctrl and cgi_dp.
// Depends on cgi_pkg, cgi_ctrl and cgi_dp.
//
//  channel   direction  handshake                 payload
//  s_axis    in         s_axis_tvalid/tready      frequency (20 b, unsigned)
//  m_axis    out        m_axis_tvalid/tready      gain_db (13 b, signed)
//  cfg       in         cfg_valid/cfg_ready       curve_select (3 b)
//
// a query that hits an endpoint finishes after the check and the final state;
// others spend a search of up to 3 steps plus one done state, a multiply, a
// numerator setup and 13 divider steps in the one-bit-per-cycle restoring
// divider; the next word can be taken at the earliest in the cycle in which
// the result appears on m_axis.
// rst is synchronous; it clears the sequencer, the output valid flag and curve_select.
// a new word is taken as soon as the sequencer is idle, even while the last
// result still waits on m_axis; the sequencer stalls in its final state only
// if that result has not been taken.
module curve_gain_interpolator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [19:0] frequency
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [12:0] gain_db
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);
  import cgi_pkg::*;

  cgi_cmd_t          cmd;
  cgi_status_t       status;
  logic [GAIN_W-1:0] gain;

  assign cfg_ready = 1'b1;

  cgi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cgi_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_sel   (cfg_data),
    .in_freq   (s_axis_tdata[FREQ_W-1:0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_gain  (gain)
  );

  // pad result word to whole bytes
  assign m_axis_tdata = {{(OUT_TDATA_W-GAIN_W){1'b0}}, gain};

endmodule
